[sv/modexp_pkg.sv]
// shared types for the modular exponentiation block
// command and status groups passed between modexp_ctrl and modexp_datapath
// no dependencies
package modexp_pkg;

    typedef enum logic [1:0] {
        MUL_SEL_BASE,
        MUL_SEL_RESULT,
        MUL_SEL_SQUARE
    } mul_sel_t;

    typedef struct packed {
        logic     load;
        logic     mul_start;
        mul_sel_t mul_sel;
        logic     shift_exp;
        logic     out_load;
    } cmd_t;

    typedef struct packed {
        logic exp_zero;
        logic exp_lsb;
        logic mul_done;
        logic out_free;
    } status_t;

endpackage

[sv/modexp_mulmod.sv]
// bit-serial shift-add-reduce modular multiplier, one multiplier bit per cycle
// no package dependencies; used by modexp_datapath
module modexp_mulmod #(
    parameter int WIDTH = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [WIDTH-1:0] a,
    input  logic [WIDTH-1:0] b,
    input  logic [WIDTH-1:0] m,
    output logic             done,
    output logic [WIDTH-1:0] product
);

    localparam int CNT_W = $clog2(WIDTH + 1);

    logic [WIDTH-1:0] a_reg;
    logic [WIDTH-1:0] mult_reg;
    logic [WIDTH-1:0] acc_reg;
    logic [WIDTH-1:0] acc_next;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    // x + y reduced once; a zero modulus wraps at the word width
    function automatic logic [WIDTH-1:0] add_reduce(
        input logic [WIDTH-1:0] x,
        input logic [WIDTH-1:0] y,
        input logic [WIDTH-1:0] md
    );
        logic [WIDTH:0] s;
        s = {1'b0, x} + {1'b0, y};
        if ((md != '0) && (s >= {1'b0, md}))
        begin
            s = s - {1'b0, md};
        end
        return s[WIDTH-1:0];
    endfunction

    always_comb
    begin
        acc_next = add_reduce(acc_reg, acc_reg, m);
        if (mult_reg[WIDTH-1])
        begin
            acc_next = add_reduce(acc_next, a_reg, m);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(WIDTH);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg    <= a;
            mult_reg <= b;
            acc_reg  <= '0;
        end
        else if (busy_reg)
        begin
            acc_reg  <= acc_next;
            mult_reg <= {mult_reg[WIDTH-2:0], 1'b0};
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

[sv/modexp_datapath.sv]
// datapath: operand registers, exponent shifter, multiplier and output register
// depends on modexp_pkg and modexp_mulmod
module modexp_datapath #(
    parameter int WIDTH     = 32,
    parameter int EXP_WIDTH = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  modexp_pkg::cmd_t    cmd,
    output modexp_pkg::status_t status,
    input  logic [31:0]         base,
    input  logic [31:0]         exponent,
    input  logic [31:0]         modulus,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [31:0]         power_mod
);

    logic [WIDTH-1:0]     b_reg;
    logic [WIDTH-1:0]     r_reg;
    logic [WIDTH-1:0]     m_reg;
    logic [EXP_WIDTH-1:0] e_reg;
    logic [31:0]          out_data_reg;
    logic                 out_valid_reg;

    logic [WIDTH-1:0]     mul_a;
    logic [WIDTH-1:0]     mul_b;
    logic [WIDTH-1:0]     mul_p;
    logic                 mul_done;

    logic [WIDTH+31:0]     base_ext;
    logic [WIDTH+31:0]     mod_ext;
    logic [EXP_WIDTH+31:0] exp_ext;
    logic [WIDTH+31:0]     res_ext;

    // fields come in at 32 bits: keep the low bits, zero-fill when wider
    assign base_ext = {{WIDTH{1'b0}}, base};
    assign mod_ext  = {{WIDTH{1'b0}}, modulus};
    assign exp_ext  = {{EXP_WIDTH{1'b0}}, exponent};
    assign res_ext  = {32'b0, r_reg};

    always_comb
    begin
        case (cmd.mul_sel)
            modexp_pkg::MUL_SEL_BASE:
            begin
                // base times one reduces the base itself
                mul_a = WIDTH'(1);
                mul_b = b_reg;
            end
            modexp_pkg::MUL_SEL_RESULT:
            begin
                mul_a = r_reg;
                mul_b = b_reg;
            end
            modexp_pkg::MUL_SEL_SQUARE:
            begin
                mul_a = b_reg;
                mul_b = b_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    modexp_mulmod #(
        .WIDTH (WIDTH)
    ) u_mulmod (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .m       (m_reg),
        .done    (mul_done),
        .product (mul_p)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            b_reg <= base_ext[WIDTH-1:0];
            m_reg <= mod_ext[WIDTH-1:0];
            e_reg <= exp_ext[EXP_WIDTH-1:0];
            r_reg <= WIDTH'(1);
        end
        else
        begin
            if (cmd.shift_exp)
            begin
                e_reg <= e_reg >> 1;
            end
            if (mul_done)
            begin
                if (cmd.mul_sel == modexp_pkg::MUL_SEL_RESULT)
                begin
                    r_reg <= mul_p;
                end
                else
                begin
                    b_reg <= mul_p;
                end
            end
        end
        if (cmd.out_load)
        begin
            out_data_reg <= res_ext[31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign status.exp_zero = (e_reg == '0);
    assign status.exp_lsb  = e_reg[0];
    assign status.mul_done = mul_done;
    assign status.out_free = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign power_mod = out_data_reg;

endmodule

[sv/modexp_ctrl.sv]
// controller: sequences reduction, multiply and square steps over the exponent
// depends on modexp_pkg
module modexp_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  modexp_pkg::status_t status,
    output modexp_pkg::cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RED_GO,
        ST_RED_WAIT,
        ST_CHECK,
        ST_MULR_GO,
        ST_MULR_WAIT,
        ST_SHIFT,
        ST_SQ_GO,
        ST_SQ_WAIT,
        ST_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next    = state_reg;
        cmd.load      = 1'b0;
        cmd.mul_start = 1'b0;
        cmd.mul_sel   = modexp_pkg::MUL_SEL_SQUARE;
        cmd.shift_exp = 1'b0;
        cmd.out_load  = 1'b0;
        in_ready      = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_RED_GO;
                end
            end
            ST_RED_GO:
            begin
                cmd.mul_sel   = modexp_pkg::MUL_SEL_BASE;
                cmd.mul_start = 1'b1;
                state_next    = ST_RED_WAIT;
            end
            ST_RED_WAIT:
            begin
                cmd.mul_sel = modexp_pkg::MUL_SEL_BASE;
                if (status.mul_done)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (status.exp_zero)
                begin
                    state_next = ST_FINISH;
                end
                else if (status.exp_lsb)
                begin
                    state_next = ST_MULR_GO;
                end
                else
                begin
                    state_next = ST_SHIFT;
                end
            end
            ST_MULR_GO:
            begin
                cmd.mul_sel   = modexp_pkg::MUL_SEL_RESULT;
                cmd.mul_start = 1'b1;
                state_next    = ST_MULR_WAIT;
            end
            ST_MULR_WAIT:
            begin
                cmd.mul_sel = modexp_pkg::MUL_SEL_RESULT;
                if (status.mul_done)
                begin
                    state_next = ST_SHIFT;
                end
            end
            ST_SHIFT:
            begin
                cmd.shift_exp = 1'b1;
                state_next    = ST_SQ_GO;
            end
            ST_SQ_GO:
            begin
                // no square is needed once the exponent has run out
                if (status.exp_zero)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    cmd.mul_start = 1'b1;
                    state_next    = ST_SQ_WAIT;
                end
            end
            ST_SQ_WAIT:
            begin
                if (status.mul_done)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[sv/modular_exponentiation.sv]
// modular exponentiation block: base to the exponent modulo the modulus
// usage: one input word on s_axis carries base, exponent and modulus; one
// result word leaves on m_axis. both channels move a word when tvalid and
// tready are high at a rising edge of clk.
// method: right-to-left square-and-multiply on a bit-serial shift-add-reduce
// multiplier that takes one multiplier bit per cycle. the base is first
// reduced by the same unit, and for each exponent bit up to the highest set
// one there is a square (none after the top bit) and another modular
// multiplication when the bit is set. an exponent of zero returns 1 after
// the base reduction.
// throughput: one word at a time; s_axis_tready is high only while idle.
// the result sits in an output register, so a new word is taken while the
// previous result waits; a finished result waits in turn until that register
// is free.
// reset: rst_n clears the controller and output valid; no result is pending.
// depends on modexp_pkg, modexp_ctrl, modexp_datapath, modexp_mulmod
module modular_exponentiation #(
    parameter int WIDTH     = 32,
    parameter int EXP_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [95:0] s_axis_tdata,  // base [31:0], exponent [63:32], modulus [95:64]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata   // power_mod [31:0]
);

    modexp_pkg::cmd_t    cmd;
    modexp_pkg::status_t status;

    modexp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    modexp_datapath #(
        .WIDTH     (WIDTH),
        .EXP_WIDTH (EXP_WIDTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .base      (s_axis_tdata[31:0]),
        .exponent  (s_axis_tdata[63:32]),
        .modulus   (s_axis_tdata[95:64]),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .power_mod (m_axis_tdata)
    );

endmodule

[dv/tb_top.sv]
// testbench for modular_exponentiation: directed and random base, exponent, modulus words
// results checked against a square-and-multiply predictor held in this file
// depends on the modular_exponentiation rtl only
`timescale 1ns / 100ps

module tb_top;

    localparam int LIMIT_CYCLES = 4_000_000;
    localparam int RANDOM_WORDS = 250;
    localparam int LONG_HOLD    = 8000;
    localparam int SETTLE       = 300;

    typedef struct {
        logic [31:0] base;
        logic [31:0] exponent;
        logic [31:0] modulus;
        bit          drain_first;
    } op_word_t;

    typedef struct {
        logic [31:0] base;
        logic [31:0] exponent;
        logic [31:0] modulus;
        logic [31:0] power_mod;
    } power_exp_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [95:0] s_axis_tdata = '0;  // base [31:0], exponent [63:32], modulus [95:64]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;       // power_mod [31:0]

    op_word_t   pending_words[$];
    power_exp_t expected_powers[$];
    op_word_t   next_word;
    power_exp_t got_power;
    power_exp_t want_power;

    int  total_words;
    int  words_sent;
    int  results_seen;
    int  error_count;
    int  cycle_count;
    int  burst_left;
    int  gap_left;
    int  hold_left;
    int  phase_left;
    bit  stall_phase;
    bit  long_hold_done;

    modular_exponentiation DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // right-to-left square-and-multiply; products of two 32-bit values fit in 64 bits
    function automatic logic [31:0] calc_power_mod(input logic [31:0] base,
                                                   input logic [31:0] exponent,
                                                   input logic [31:0] modulus);
        logic [63:0] b;
        logic [63:0] r;
        logic [63:0] m;
        logic [31:0] e;
        b = {32'd0, base};
        m = {32'd0, modulus};
        e = exponent;
        r = 64'd1;
        if (m != 0)
            b = b % m;
        while (e != 0)
        begin
            if (e[0])
                r = (m != 0) ? ((r % m) * b) % m : (r * b) & 64'hFFFF_FFFF;
            e = e >> 1;
            b = (m != 0) ? (b * b) % m : (b * b) & 64'hFFFF_FFFF;
        end
        return r[31:0];
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        error_count++;
    endtask

    task automatic queue_word(input logic [31:0] base, input logic [31:0] exponent,
                              input logic [31:0] modulus, input bit drain_first);
        op_word_t w;
        w.base        = base;
        w.exponent    = exponent;
        w.modulus     = modulus;
        w.drain_first = drain_first;
        pending_words.push_back(w);
    endtask

    // sender: bursts of words with random gaps, optionally draining before a word
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            burst_left    = 1;
            gap_left      = 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                got_power.base      = s_axis_tdata[31:0];
                got_power.exponent  = s_axis_tdata[63:32];
                got_power.modulus   = s_axis_tdata[95:64];
                got_power.power_mod = calc_power_mod(s_axis_tdata[31:0], s_axis_tdata[63:32],
                                                     s_axis_tdata[95:64]);
                expected_powers.push_back(got_power);
                words_sent++;
            end
            if (s_axis_tvalid && !s_axis_tready)
            begin
                // word still on offer, hold it
            end
            else if (gap_left > 0)
            begin
                gap_left--;
                s_axis_tvalid <= 1'b0;
            end
            else if (pending_words.size() == 0)
                s_axis_tvalid <= 1'b0;
            else if (pending_words[0].drain_first && expected_powers.size() != 0)
                s_axis_tvalid <= 1'b0;
            else
            begin
                next_word = pending_words.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {next_word.modulus, next_word.exponent, next_word.base};
                burst_left--;
                if (burst_left <= 0)
                begin
                    if ($urandom_range(0, 4) == 0)
                    begin
                        burst_left = $urandom_range(10, 40);
                        gap_left   = 0;
                    end
                    else
                    begin
                        burst_left = $urandom_range(1, 6);
                        gap_left   = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 2500)
                                                                 : $urandom_range(0, 20);
                    end
                end
            end
        end
    end

    // receiver: runs of full readiness and runs of sparse readiness, plus one long hold
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            hold_left      = 0;
            phase_left     = 0;
            stall_phase    = 1'b0;
            long_hold_done = 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else if (!long_hold_done && results_seen >= 40)
        begin
            long_hold_done = 1'b1;
            hold_left      = LONG_HOLD;
            m_axis_tready <= 1'b0;
        end
        else if (phase_left > 0)
        begin
            phase_left--;
            m_axis_tready <= stall_phase ? ($urandom_range(0, 7) == 0) : 1'b1;
        end
        else
        begin
            phase_left  = $urandom_range(20, 3000);
            stall_phase = ($urandom_range(0, 2) == 0);
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            results_seen++;
            if (expected_powers.size() == 0)
                report_mismatch($sformatf("result %h with no word pending", m_axis_tdata));
            else
            begin
                want_power = expected_powers.pop_front();
                if (m_axis_tdata !== want_power.power_mod)
                    report_mismatch($sformatf("base=%h exp=%h mod=%h got %h want %h",
                                              want_power.base, want_power.exponent,
                                              want_power.modulus, m_axis_tdata,
                                              want_power.power_mod));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        logic [31:0] b;
        logic [31:0] e;
        logic [31:0] m;
        int          k;

        // directed: extremes, zero exponent, modulus of one and of zero, base not below modulus
        queue_word(32'd0,          32'd0,          32'd1,          1'b0);
        queue_word(32'hFFFF_FFFF,  32'd0,          32'd1,          1'b0);
        queue_word(32'd0,          32'd5,          32'd7,          1'b0);
        queue_word(32'd9,          32'd1,          32'd1,          1'b0);
        queue_word(32'hFFFF_FFFF,  32'hFFFF_FFFF,  32'hFFFF_FFFF,  1'b0);
        queue_word(32'hFFFF_FFFE,  32'hFFFF_FFFF,  32'hFFFF_FFFF,  1'b0);
        queue_word(32'hFFFF_FFFF,  32'd1,          32'hFFFF_FFFB,  1'b0);
        queue_word(32'd3,          32'd0,          32'd0,          1'b0);
        queue_word(32'd3,          32'd20,         32'd0,          1'b0);
        queue_word(32'hFFFF_FFFF,  32'hFFFF_FFFF,  32'd0,          1'b0);
        queue_word(32'h1234_5678,  32'h8000_0000,  32'd0,          1'b0);
        queue_word(32'd12345,      32'd7,          32'd2,          1'b0);
        queue_word(32'd2,          32'd31,         32'hFFFF_FFFB,  1'b0);
        queue_word(32'd2,          32'd32,         32'hFFFF_FFFF,  1'b0);
        queue_word(32'hDEAD_BEEF,  32'h8000_0000,  32'hFFFF_FFFB,  1'b0);
        queue_word(32'd1,          32'hFFFF_FFFF,  32'h8000_0000,  1'b0);
        queue_word(32'd100,        32'd3,          32'd100,        1'b0);
        queue_word(32'd1000,       32'd3,          32'd7,          1'b0);
        queue_word(32'hFFFF_FFFA,  32'd2,          32'hFFFF_FFFB,  1'b0);
        queue_word(32'h8000_0001,  32'h5555_5555,  32'hAAAA_AAAB,  1'b0);
        queue_word(32'h7FFF_FFFF,  32'hAAAA_AAAA,  32'h8000_0001,  1'b0);

        for (k = 0; k < RANDOM_WORDS; k++)
        begin
            b = $urandom;
            case ($urandom_range(0, 3))
                0:       e = $urandom_range(0, 3);
                1:       e = $urandom;
                default: e = $urandom >> $urandom_range(0, 31);
            endcase
            case ($urandom_range(0, 5))
                0:       m = $urandom_range(1, 16);
                1:       m = $urandom | 32'h8000_0000;
                2:       m = $urandom >> $urandom_range(1, 28);
                default: m = $urandom;
            endcase
            if (m == 0)
                m = 32'd1;
            if ($urandom_range(0, 9) == 0)
                b = m + $urandom_range(0, 3);
            queue_word(b, e, m, (k == 0) || (k == 120) || (k == 200));
        end
        total_words = pending_words.size();

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (words_sent < total_words || expected_powers.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

[sim.f]
sv/modexp_pkg.sv
sv/modexp_mulmod.sv
sv/modexp_datapath.sv
sv/modexp_ctrl.sv
sv/modular_exponentiation.sv
dv/tb_top.sv
